[design/lmfsr_pkg.sv]
// shared types, codes and row helper functions for the led matrix frame and refresh unit
package lmfsr_pkg;

  localparam int MATRIX_ROWS = 8;
  localparam int GLYPH_ROWS  = 5;

  // operation codes carried in the input tuser
  localparam logic [2:0] OP_CLEAR = 3'd0;
  localparam logic [2:0] OP_PIXEL = 3'd1;
  localparam logic [2:0] OP_GLYPH = 3'd2;
  localparam logic [2:0] OP_START = 3'd3;
  localparam logic [2:0] OP_TICK  = 3'd4;

  // display controller command bytes
  localparam logic [7:0] CMD_DATA   = 8'h44;
  localparam logic [7:0] CMD_ADDR   = 8'hC0;
  localparam logic [7:0] CMD_SHOW   = 8'h88;
  localparam logic [2:0] LEVEL_MASK = 3'h7;

  // write positions inside one 80-write row slot
  localparam logic [6:0] POS_FIRST      = 7'd0;
  localparam logic [6:0] POS_CMD_BIT_LO = 7'd1;
  localparam logic [6:0] POS_CMD_BIT_HI = 7'd24;
  localparam logic [6:0] POS_CMD_END    = 7'd25;
  localparam logic [6:0] POS_ADDR_START = 7'd26;
  localparam logic [6:0] POS_ADDR_BIT_LO = 7'd27;
  localparam logic [6:0] POS_ADDR_BIT_HI = 7'd74;
  localparam logic [6:0] POS_ADDR_END   = 7'd75;
  localparam logic [6:0] POS_SEP_DATA   = 7'd76;
  localparam logic [6:0] POS_SEP_CLK_LO = 7'd77;
  localparam logic [6:0] POS_SEP_CLK_HI = 7'd78;
  localparam logic [6:0] POS_LAST       = 7'd79;

  // row slot index of the closing display command
  localparam logic [3:0] ROW_FINAL = 4'd8;

  // phases of one serial bit
  localparam logic [1:0] PH_CLK_LO = 2'd0;
  localparam logic [1:0] PH_DATA   = 2'd1;
  localparam logic [1:0] PH_CLK_HI = 2'd2;

  typedef logic [7:0] row_t;

  function automatic logic [4:0] mirror5(input logic [4:0] c);
    mirror5 = {c[0], c[1], c[2], c[3], c[4]};
  endfunction

  // left by x when x is positive, right by -x otherwise, kept to one row byte
  function automatic row_t shift_row(input logic [4:0] v, input logic signed [4:0] x);
    logic [20:0] wide;
    logic [4:0]  nx;
    wide = {16'd0, v} << x[3:0];
    nx   = 5'(-x);
    if (x > 5'sd0) begin
      shift_row = wide[7:0];
    end else begin
      shift_row = {3'b000, v >> nx};
    end
  endfunction

endpackage

[design/led_matrix_frame_and_serial_refresh_unit.sv]
// top level: 8x8 frame store, glyph drawing and two-wire serial refresh sequencer
//
// usage
//   input channel in_*: one item per handshake, in_tuser holds the operation
//   (clear, pixel, draw glyph, start refresh, tick), in_tdata the operands
//   result channel out_*: exactly one item per input item, carrying the pin
//   levels after that item, the busy flag and the dropped-item flag
//   cfg_*: brightness level, written with cfg_wr_en, takes effect at once
// timing
//   an accepted item lands in an input register and is executed as it moves
//   on into the output register, where its result appears
//   one item per cycle sustained while out_tready stays high; every item is a single frame update or a
//   single pin write done by the refresh counters in one pass
//   a full refresh takes 666 tick items (8 rows of 80 writes plus 26)
// reset
//   frame cleared, both pins high, no refresh running, brightness 7
// stalls
//   while out_tready is low the output register holds its item, the input
//   register can still take one more item, then in_tready drops
module led_matrix_frame_and_serial_refresh_unit
  import lmfsr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // x_pos[4:0], y_pos[7:5], pixel_on[8], glyph_rows[33:9], zero pad
  input  logic [39:0] in_tdata,
  // operation[2:0]
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // data_pin[0], clock_pin[1], busy_res[2], ignored[3], zero pad
  output logic [7:0]  out_tdata,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_wr_data
);

  // input register
  logic              in_valid_r;
  logic [2:0]        op_r;
  logic signed [4:0] x_r;
  logic [2:0]        y_r;
  logic              on_r;
  logic [24:0]       glyph_r;

  // output register
  logic              out_valid_r;
  logic [3:0]        out_bits_r;

  // block state
  row_t              frame_r   [MATRIX_ROWS];
  row_t              frame_nxt [MATRIX_ROWS];
  row_t              glyph_new [MATRIX_ROWS];
  logic              data_r, data_nxt;
  logic              clk_r, clk_nxt;
  logic              busy_r, busy_nxt;
  logic [3:0]        row_r, row_nxt;     // row slot, ROW_FINAL for the closing command
  logic [6:0]        pos_r, pos_nxt;     // write position inside the slot
  logic [1:0]        phase_r, phase_nxt; // phase of the current serial bit
  logic [3:0]        bit_r, bit_nxt;     // bit counter inside a framed transfer
  logic [2:0]        level_r;

  logic              adv;
  logic              dropped;
  logic              is_final;
  logic              is_bit;
  logic [7:0]        tx_byte;

  // item moves from input register to output register
  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_bits_r};

  // glyph placement: clamp top row, flip vertically, mirror and shift each row
  logic [2:0] y_clamp;
  logic [4:0] glyph_mask5;
  row_t       glyph_mask;
  assign y_clamp    = (y_r > 3'(MATRIX_ROWS - GLYPH_ROWS)) ? 3'(MATRIX_ROWS - GLYPH_ROWS) : y_r;
  assign glyph_mask5 = 5'h1F;
  assign glyph_mask = shift_row(glyph_mask5, x_r);

  for (genvar g = 0; g < MATRIX_ROWS; g++) begin : g_row
    logic [3:0]  row_ofs;
    logic        hit;
    logic [2:0]  src_k;
    logic [5:0]  src_idx;
    logic [24:0] src_sh;
    row_t        placed;
    assign row_ofs = 4'(g) - {1'b0, y_clamp};
    assign hit     = (3'(g) >= y_clamp) && (row_ofs < 4'(GLYPH_ROWS));
    assign src_k   = 3'(GLYPH_ROWS - 1) - row_ofs[2:0];
    assign src_idx = {1'b0, src_k, 2'b00} + {3'b000, src_k};
    // rows past the supplied bits shift out to zero
    assign src_sh  = glyph_r >> src_idx;
    assign placed  = shift_row(mirror5(src_sh[4:0]), x_r);
    assign glyph_new[g] = hit ? ((frame_r[g] & ~glyph_mask) | (placed & glyph_mask))
                              : frame_r[g];
  end

  // refresh write decode
  assign is_final = (row_r == ROW_FINAL);
  always_comb begin
    is_bit = (pos_r >= POS_CMD_BIT_LO) && (pos_r <= POS_CMD_BIT_HI);
    if (!is_final && (pos_r >= POS_ADDR_BIT_LO) && (pos_r <= POS_ADDR_BIT_HI)) begin
      is_bit = 1'b1;
    end
    if (pos_r <= POS_CMD_BIT_HI) begin
      tx_byte = is_final ? (CMD_SHOW | {5'b00000, level_r & LEVEL_MASK}) : CMD_DATA;
    end else if (bit_r[3]) begin
      tx_byte = frame_r[row_r[2:0]];
    end else begin
      tx_byte = CMD_ADDR | {5'b00000, row_r[2:0]};
    end
  end

  always_comb begin
    frame_nxt = frame_r;
    data_nxt  = data_r;
    clk_nxt   = clk_r;
    busy_nxt  = busy_r;
    row_nxt   = row_r;
    pos_nxt   = pos_r;
    phase_nxt = phase_r;
    bit_nxt   = bit_r;
    dropped   = 1'b0;
    if (adv) begin
      if (op_r == OP_TICK) begin
        if (busy_r) begin
          // one pin write
          if (is_bit) begin
            case (phase_r)
              PH_CLK_LO: clk_nxt  = 1'b0;
              PH_DATA:   data_nxt = tx_byte[bit_r[2:0]];
              default:   clk_nxt  = 1'b1;
            endcase
            if (phase_r == PH_CLK_HI) begin
              phase_nxt = PH_CLK_LO;
              bit_nxt   = bit_r + 4'd1;
            end else begin
              phase_nxt = phase_r + 2'd1;
            end
          end else begin
            phase_nxt = PH_CLK_LO;
            bit_nxt   = '0;
            case (pos_r)
              POS_FIRST, POS_ADDR_START, POS_SEP_DATA: data_nxt = 1'b0;
              POS_CMD_END, POS_ADDR_END, POS_LAST:     data_nxt = 1'b1;
              POS_SEP_CLK_LO:                          clk_nxt  = 1'b0;
              POS_SEP_CLK_HI:                          clk_nxt  = 1'b1;
              default: ;
            endcase
          end
          // step the sequencer
          if (is_final && (pos_r == POS_CMD_END)) begin
            busy_nxt = 1'b0;
            row_nxt  = '0;
            pos_nxt  = '0;
          end else if (pos_r == POS_LAST) begin
            pos_nxt = '0;
            row_nxt = row_r + 4'd1;
          end else begin
            pos_nxt = pos_r + 7'd1;
          end
        end
      end else if (busy_r) begin
        dropped = 1'b1;
      end else begin
        case (op_r)
          OP_CLEAR: begin
            for (int r = 0; r < MATRIX_ROWS; r++) begin
              frame_nxt[r] = '0;
            end
          end
          OP_PIXEL: frame_nxt[y_r][x_r[2:0]] = on_r;
          OP_GLYPH: frame_nxt = glyph_new;
          OP_START: begin
            busy_nxt  = 1'b1;
            row_nxt   = '0;
            pos_nxt   = '0;
            phase_nxt = PH_CLK_LO;
            bit_nxt   = '0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int r = 0; r < MATRIX_ROWS; r++) begin
        frame_r[r] <= '0;
      end
      data_r  <= 1'b1;
      clk_r   <= 1'b1;
      busy_r  <= 1'b0;
      row_r   <= '0;
      pos_r   <= '0;
      phase_r <= PH_CLK_LO;
      bit_r   <= '0;
      level_r <= LEVEL_MASK;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      frame_r <= frame_nxt;
      data_r  <= data_nxt;
      clk_r   <= clk_nxt;
      busy_r  <= busy_nxt;
      row_r   <= row_nxt;
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      bit_r   <= bit_nxt;
      if (cfg_wr_en) begin
        level_r <= cfg_wr_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      op_r    <= in_tuser;
      x_r     <= in_tdata[4:0];
      y_r     <= in_tdata[7:5];
      on_r    <= in_tdata[8];
      glyph_r <= in_tdata[33:9];
    end
    if (adv) begin
      out_bits_r <= {dropped, busy_nxt, clk_nxt, data_nxt};
    end
  end

`ifndef SYNTHESIS
  a_idle_counters: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (row_r == 4'd0 && pos_r == 7'd0 && bit_r == 4'd0))
    else $error("sequencer counters not at rest while idle");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (row_r <= ROW_FINAL) && (pos_r <= POS_LAST) && (!is_final || pos_r <= POS_CMD_END))
    else $error("refresh position out of range");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != 2'd3)
    else $error("bit phase out of range");

  a_drop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_bits_r[3]) |-> out_bits_r[2])
    else $error("dropped item reported without a refresh running");

  a_stall_only: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_valid_r && !out_tready))
    else $error("input stalled without output back pressure");
`endif

endmodule

[tb/sv/led_matrix_frame_and_serial_refresh_unit_tb.sv]
// testbench for the led matrix frame store and serial refresh unit: frame edits, refresh pin writes
module led_matrix_frame_and_serial_refresh_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lmfsr_pkg::*;

  // refresh layout: every row slot is a framed data command, a framed address
  // plus row byte write and a separator pulse; the last slot is the show command
  localparam int ROW_SLOT      = 80;
  localparam int FRAMED_WRITES = 26;
  localparam int ADDR_CLOSE    = 49;
  localparam int SEP_FIRST     = 76;
  localparam int TOTAL_WRITES  = MATRIX_ROWS * ROW_SLOT + FRAMED_WRITES;

  // operation codes the block does not define
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  localparam int HALF_PERIOD = 5;
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES = 60;
  localparam int CYCLE_LIMIT = 200000;

  // result fields from the lowest bit up: data pin, clock pin, busy, ignored
  typedef struct packed {
    logic ignored;
    logic busy;
    logic clk_pin;
    logic data_pin;
  } pin_state_t;

  // mirror of the block: frame, pin levels, refresh position and brightness
  class refresh_scoreboard;
    row_t        frame [MATRIX_ROWS];
    logic        data_lvl;
    logic        clk_lvl;
    logic        refreshing;
    int unsigned step;
    logic [2:0]  level;
    pin_state_t  pending_q [$];
    int          errors;

    function new();
      foreach (frame[r]) frame[r] = '0;
      data_lvl   = 1'b1;
      clk_lvl    = 1'b1;
      refreshing = 1'b0;
      step       = 0;
      level      = 3'd7;
      errors     = 0;
    endfunction

    function bit drained();
      return pending_q.size() == 0;
    endfunction

    // one write of a serial bit: clock low, data set, clock high
    function void serial_bit(logic [1:0] phase, logic b);
      if (phase == PH_CLK_LO) clk_lvl = 1'b0;
      else if (phase == PH_DATA) data_lvl = b;
      else clk_lvl = 1'b1;
    endfunction

    // start condition, eight bits lsb first, then data released
    function void framed_byte(int unsigned p, logic [7:0] octet);
      if (p == 0) data_lvl = 1'b0;
      else if (p >= FRAMED_WRITES - 1) data_lvl = 1'b1;
      else serial_bit(2'((p - 1) % 3), octet[(p - 1) / 3]);
    endfunction

    function void refresh_one(int unsigned s);
      int unsigned r, p, q, b;
      logic [7:0]  octet;
      if (s >= MATRIX_ROWS * ROW_SLOT) begin
        // brightness is read live here
        framed_byte(s - MATRIX_ROWS * ROW_SLOT, CMD_SHOW | {5'd0, level});
        return;
      end
      r = (s / ROW_SLOT) % MATRIX_ROWS;
      p = s % ROW_SLOT;
      if (p < FRAMED_WRITES) begin
        framed_byte(p, CMD_DATA);
      end else if (p < SEP_FIRST) begin
        q = p - FRAMED_WRITES;
        if (q == 0) data_lvl = 1'b0;
        else if (q == ADDR_CLOSE) data_lvl = 1'b1;
        else begin
          b = (q - 1) / 3;
          octet = (b < 8) ? (CMD_ADDR | 8'(r)) : frame[r];
          serial_bit(2'((q - 1) % 3), octet[b % 8]);
        end
      end else begin
        case (p - SEP_FIRST)
          0: data_lvl = 1'b0;
          1: clk_lvl = 1'b0;
          2: clk_lvl = 1'b1;
          default: data_lvl = 1'b1;
        endcase
      end
    endfunction

    // left by x when positive, right by -x otherwise, bits past the row lost
    function row_t slide(logic [4:0] v, logic signed [4:0] x);
      logic [15:0] w;
      int          n;
      n = x;
      w = {11'd0, v};
      w = (n > 0) ? (w << n) : (w >> (-n));
      return w[7:0];
    endfunction

    function void draw(logic [24:0] g, logic signed [4:0] x, logic [2:0] y);
      int   top, r;
      row_t mask, bits;
      logic [4:0] src, flip;
      top  = (y > MATRIX_ROWS - GLYPH_ROWS) ? MATRIX_ROWS - GLYPH_ROWS : y;
      mask = slide(5'h1F, x);
      for (int i = 0; i < GLYPH_ROWS; i++) begin
        // vertical flip, then each row mirrored so the leftmost pixel is bit 0
        src = g[5 * (GLYPH_ROWS - 1 - i) +: 5];
        for (int j = 0; j < 5; j++) flip[j] = src[4 - j];
        bits = slide(flip, x);
        r = (top + i) % MATRIX_ROWS;
        frame[r] = (frame[r] & ~mask) | (bits & mask);
      end
    endfunction

    function void note_item(logic [2:0] op, logic [39:0] d);
      logic signed [4:0] x;
      logic [2:0]        y;
      pin_state_t        e;
      x = d[4:0];
      y = d[7:5];
      e.ignored = 1'b0;
      if (op == OP_TICK) begin
        if (refreshing) begin
          refresh_one(step);
          step++;
          if (step >= TOTAL_WRITES) begin
            step = 0;
            refreshing = 1'b0;
          end
        end
      end else if (refreshing) begin
        e.ignored = 1'b1;
      end else begin
        case (op)
          OP_CLEAR: foreach (frame[r]) frame[r] = '0;
          OP_PIXEL: frame[y][x[2:0]] = d[8];
          OP_GLYPH: draw(d[33:9], x, y);
          OP_START: begin
            refreshing = 1'b1;
            step = 0;
          end
          default: ;
        endcase
      end
      e.data_pin = data_lvl;
      e.clk_pin  = clk_lvl;
      e.busy     = refreshing;
      pending_q.push_back(e);
    endfunction

    function void field_check(string name, logic want, logic got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0b actual %0b", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [7:0] t);
      pin_state_t got, want;
      got = t[3:0];
      if (pending_q.size() == 0) begin
        $display("%0t: result with nothing expected, expected none actual %h", $time, t);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      field_check("data_pin", want.data_pin, got.data_pin);
      field_check("clock_pin", want.clk_pin, got.clk_pin);
      field_check("busy", want.busy, got.busy);
      field_check("ignored", want.ignored, got.ignored);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        cfg_wr_en;
  logic [2:0]  cfg_wr_data;

  refresh_scoreboard board;
  int send_idle_pct;
  int recv_idle_pct;
  int items_sent;
  int stall_reqs;
  int stalls_served = 0;
  int cycle_count = 0;

  led_matrix_frame_and_serial_refresh_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #(HALF_PERIOD) clk = 1'b1;
    #(HALF_PERIOD) clk = 1'b0;
  end

  // run guard: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: random back-pressure, plus a long hold-off whenever one is
  // requested so the input register fills and in_tready drops
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_reqs > stalls_served) begin
        stalls_served++;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // every accepted result is checked against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata);
  end

  // x in bits 4:0, y in 7:5, pixel_on in 8, glyph rows in 33:9, pad on top
  function automatic logic [39:0] pack_operands(int x, int y, logic on, logic [24:0] g);
    return {6'd0, g, on, 3'(y), 5'(x)};
  endfunction

  function automatic logic [39:0] random_operands();
    return pack_operands(int'($urandom_range(16)) - 8, $urandom_range(7),
                         1'($urandom), 25'($urandom));
  endfunction

  // offer one item at the falling edge, hold it until the handshake
  task automatic push_item(input logic [2:0] op, input logic [39:0] d);
    // idling pattern shifts with progress: sender light / receiver heavy,
    // then the reverse, then none
    if (items_sent < 400) begin
      send_idle_pct = 6;
      recv_idle_pct = 82;
    end else if (items_sent < 800) begin
      send_idle_pct = 82;
      recv_idle_pct = 6;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    board.note_item(op, d);
    items_sent++;
  endtask

  function automatic logic [2:0] random_non_tick();
    logic [2:0] o;
    o = 3'($urandom_range(6));
    if (o >= OP_TICK) o++;
    return o;
  endfunction

  // mostly frame edits, mixed with ticks and undefined codes
  task automatic push_random_edit();
    int         pick;
    logic [2:0] op;
    pick = $urandom_range(99);
    if (pick < 4) op = OP_CLEAR;
    else if (pick < 40) op = OP_PIXEL;
    else if (pick < 85) op = OP_GLYPH;
    else if (pick < 92) op = OP_TICK;
    else op = 3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
    push_item(op, random_operands());
  endtask

  // ticks until the refresh is over, with dropped items mixed in
  task automatic finish_refresh(input int noise_pct);
    while (board.refreshing) begin
      if ($urandom_range(99) < noise_pct) push_item(random_non_tick(), random_operands());
      else push_item(OP_TICK, random_operands());
    end
  endtask

  // brightness only changes with nothing in flight
  task automatic set_brightness(input logic [2:0] lvl);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (!board.drained()) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= lvl;
    board.level = lvl;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    board         = new();
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = OP_CLEAR;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    send_idle_pct = 6;
    recv_idle_pct = 82;
    items_sent    = 0;
    stall_reqs    = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // idle behavior: tick with no refresh and the undefined codes
    push_item(OP_TICK, pack_operands(0, 0, 1'b0, 25'd0));
    push_item(OP_SPARE_LO, pack_operands(-8, 7, 1'b1, 25'h1FFFFFF));
    push_item(OP_SPARE_HI, pack_operands(8, 0, 1'b0, 25'd0));
    // pixels at the corners, negative columns use the low three bits
    push_item(OP_PIXEL, pack_operands(7, 7, 1'b1, 25'd0));
    push_item(OP_PIXEL, pack_operands(0, 0, 1'b1, 25'd0));
    push_item(OP_PIXEL, pack_operands(-1, 7, 1'b0, 25'd0));
    push_item(OP_PIXEL, pack_operands(-8, 3, 1'b1, 25'd0));
    push_item(OP_PIXEL, pack_operands(8, 4, 1'b1, 25'd0));
    // glyphs: full block, shifted fully off either side, clamped top row,
    // partial shifts and an all-zero glyph that punches a hole
    push_item(OP_GLYPH, pack_operands(0, 0, 1'b0, 25'h1FFFFFF));
    push_item(OP_GLYPH, pack_operands(8, 1, 1'b0, 25'h1FFFFFF));
    push_item(OP_GLYPH, pack_operands(-8, 2, 1'b0, 25'h1FFFFFF));
    push_item(OP_GLYPH, pack_operands(3, 7, 1'b1, 25'h0AAAAAA));
    push_item(OP_GLYPH, pack_operands(-2, 5, 1'b0, 25'h1234567));
    push_item(OP_GLYPH, pack_operands(1, 2, 1'b0, 25'd0));
    push_item(OP_GLYPH, pack_operands(-1, 0, 1'b1, 25'h1555555));
    push_item(OP_CLEAR, pack_operands(0, 0, 1'b0, 25'd0));
    push_item(OP_PIXEL, pack_operands(5, 6, 1'b1, 25'd0));
    push_item(OP_GLYPH, pack_operands(2, 4, 1'b0, 25'h0F0F0F3));

    // refresh at a written brightness; everything but ticks is dropped
    // meanwhile, and the receiver holds off for a long stretch
    set_brightness(3'($urandom_range(6)));
    push_item(OP_START, pack_operands(0, 0, 1'b0, 25'd0));
    push_item(OP_START, pack_operands(0, 0, 1'b0, 25'd0));
    push_item(OP_CLEAR, pack_operands(0, 0, 1'b0, 25'd0));
    push_item(OP_PIXEL, pack_operands(1, 1, 1'b1, 25'd0));
    push_item(OP_GLYPH, pack_operands(0, 0, 1'b0, 25'h1FFFFFF));
    push_item(OP_SPARE_HI, pack_operands(0, 0, 1'b0, 25'd0));
    stall_reqs++;
    finish_refresh(8);
    repeat (4) push_item(OP_TICK, random_operands());

    // random edits after the refresh
    repeat (450) push_random_edit();

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (!board.drained()) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
